>>> design/svr_pkg.sv
package svr_pkg;

  localparam int unsigned MAX_SLABS_DEF    = 64;
  localparam int unsigned BUFFER_TYPES_DEF = 4;
  localparam int unsigned TYPE_FIELD_W     = 4;
  localparam int unsigned QUEUE_DEPTH      = 4;
  localparam int unsigned QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W           = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ADDR_W           = 5;

  localparam logic [63:0] RST_MAX_SLAB_REPAIR  = 64'd4096;
  localparam logic [63:0] RST_MAX_TOTAL_REPAIR = 64'd65536;
  localparam logic [63:0] RST_MAX_UNCOND       = 64'd64;

  typedef enum logic [1:0] {
    OP_SLAB   = 2'd0,
    OP_PAGE   = 2'd1,
    OP_FINISH = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_REPAIR_ENABLE  = 2'd0,
    REG_MAX_SLAB       = 2'd1,
    REG_MAX_TOTAL      = 2'd2,
    REG_MAX_UNCOND     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] alignment;
    logic [63:0] slab_size;
    logic [31:0] slab_flags;
    logic [31:0] page_size;
    logic [31:0] page_slab;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  slab_position;
    logic [63:0] new_slab_size;
    logic        was_repaired;
    logic        valid_res;
    logic [6:0]  repair_count;
    logic [63:0] added_bytes;
    logic        last;
  } out_word_t;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    op_t                     op;
    logic                    align_ok;
    logic [4:0]              align_log;
    logic [63:0]             slab_size;
    logic [TYPE_FIELD_W-1:0] slab_type;
    logic                    page_neg;
    logic [30:0]             page_size;
    logic [31:0]             page_slab;
  } cmd_t;

  typedef struct packed {
    logic        repair_enable;
    logic [63:0] max_slab_repair;
    logic [63:0] max_total_repair;
    logic [63:0] max_uncond_repair;
  } cfg_t;

endpackage

>>> design/slab_layout_validate_repair.sv
// A word is registered in the input stage and then passes through the command queue.
// Back end: a slab word is taken in the idle state, a page word in offset read, align and
// advance steps, a finish word in the walk (read, align, add, repair when needed, align, add
// per slab), the growth check (subtract, limit, add per buffer type) and the emit (read and
// output per result word). All checked adds use the single shared 64-bit checked adder.
// Reset is synchronous and active high: it clears control state, the offset valid bits,
// the cursors and the registers to their defaults; the memories need no clearing pass.
module slab_layout_validate_repair
  import svr_pkg::*;
#(
  parameter int unsigned MAX_SLABS    = MAX_SLABS_DEF,
  parameter int unsigned BUFFER_TYPES = BUFFER_TYPES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  // The front end registers and classifies each word; the queue decouples it
  // from the back end, which owns the slab memories and the finish walk.
  cfg_t     cfg;
  logic     push;
  cmd_t     push_cmd;
  logic     q_full;
  logic     q_avail;
  logic     q_pop;
  cmd_t     q_head;
  reg_idx_t reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[4:3]);

  // Registers sit at eight-byte steps because the limits are 64 bits wide.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repair_enable     <= 1'b0;
      cfg.max_slab_repair   <= RST_MAX_SLAB_REPAIR;
      cfg.max_total_repair  <= RST_MAX_TOTAL_REPAIR;
      cfg.max_uncond_repair <= RST_MAX_UNCOND;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_REPAIR_ENABLE: cfg.repair_enable     <= pwdata[0];
        REG_MAX_SLAB:      cfg.max_slab_repair   <= pwdata;
        REG_MAX_TOTAL:     cfg.max_total_repair  <= pwdata;
        REG_MAX_UNCOND:    cfg.max_uncond_repair <= pwdata;
        default:           cfg.repair_enable     <= cfg.repair_enable;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_REPAIR_ENABLE: prdata = 64'(cfg.repair_enable);
      REG_MAX_SLAB:      prdata = cfg.max_slab_repair;
      REG_MAX_TOTAL:     prdata = cfg.max_total_repair;
      REG_MAX_UNCOND:    prdata = cfg.max_uncond_repair;
      default:           prdata = '0;
    endcase
  end

  svr_front #(
    .BUFFER_TYPES (BUFFER_TYPES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  svr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  // The back end drives an output register, so a waiting result word does
  // not stop the front end from accepting further words until the command
  // queue is full.
  svr_back #(
    .MAX_SLABS    (MAX_SLABS),
    .BUFFER_TYPES (BUFFER_TYPES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_avail (q_avail),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> design/svr_front.sv
module svr_front
  import svr_pkg::*;
#(
  parameter int unsigned BUFFER_TYPES = BUFFER_TYPES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  output logic     push,
  output cmd_t     push_cmd,
  input  logic     q_full
);

  logic        st_valid;
  cmd_t        st_cmd;
  cmd_t        cls;
  logic [31:0] al;
  logic [4:0]  lg;

  assign push     = st_valid && !q_full;
  assign push_cmd = st_cmd;
  assign in_ready = !st_valid || !q_full;
  assign al       = in_data.alignment;

  // The log of a power of two is the OR of the indices of its set bits.
  always_comb begin
    lg = '0;
    for (int b = 0; b < 32; b++) begin
      if (al[b]) begin
        lg = lg | 5'(b);
      end
    end
  end

  always_comb begin
    cls.op        = op_t'(in_data.operation);
    cls.align_ok  = (al != '0) && !al[31] && ((al & (al - 32'd1)) == '0);
    cls.align_log = cls.align_ok ? lg : '0;
    cls.slab_size = in_data.slab_size;
    cls.slab_type = in_data.slab_flags[TYPE_FIELD_W-1:0] & TYPE_FIELD_W'(BUFFER_TYPES - 1);
    cls.page_neg  = in_data.page_size[31];
    cls.page_size = in_data.page_size[30:0];
    cls.page_slab = in_data.page_slab;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      // Unknown operations are dropped here and never reach the back end.
      st_valid <= (cls.op != OP_NOP);
    end else if (push) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      st_cmd <= cls;
    end
  end

endmodule

>>> design/svr_queue.sv
module svr_queue
  import svr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign avail = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> design/svr_back.sv
module svr_back
  import svr_pkg::*;
#(
  parameter int unsigned MAX_SLABS    = MAX_SLABS_DEF,
  parameter int unsigned BUFFER_TYPES = BUFFER_TYPES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      cmd_avail,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int unsigned IDX_W  = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SLABS + 1);
  localparam int unsigned TYPE_W = (BUFFER_TYPES > 1) ? $clog2(BUFFER_TYPES) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_PG_CHK, S_PG_ADD,
    S_FN_RD, S_FN_ORG_AL, S_FN_ORG_ADD, S_FN_REP, S_FN_FIX_AL, S_FN_FIX_ADD,
    S_TY_SUB, S_TY_LIM, S_TY_ADD,
    S_EM_RD, S_EM_OUT
  } state_t;

  function automatic logic [63:0] lg_mask(input logic [4:0] lg);
    lg_mask = (64'd1 << lg) - 64'd1;
  endfunction

  state_t state;

  logic [63:0]       size_mem [MAX_SLABS];
  logic [63:0]       new_mem  [MAX_SLABS];
  logic [63:0]       off_mem  [MAX_SLABS];
  logic [4:0]        alog_mem [MAX_SLABS];
  logic [TYPE_W-1:0] type_mem [MAX_SLABS];
  logic [MAX_SLABS-1:0] off_vld;
  logic [MAX_SLABS-1:0] rep;

  logic [63:0]       size_rd, new_rd, off_rd;
  logic [4:0]        alog_rd;
  logic [TYPE_W-1:0] type_rd;
  logic              off_vld_rd;

  logic [63:0] ocur [BUFFER_TYPES];
  logic [63:0] fcur [BUFFER_TYPES];

  logic [CNT_W-1:0]  total;
  logic              pages_started;
  logic              failed;
  logic [CNT_W-1:0]  repairs;
  logic [63:0]       bytes_added;
  logic              ok;
  logic [IDX_W-1:0]  idx;
  logic [TYPE_W-1:0] k;
  logic [4:0]        p_log;
  logic [63:0]       p_size;
  logic [63:0]       acc;
  logic              short_f;
  logic [63:0]       rep_amt;
  logic [63:0]       lim;
  logic [63:0]       g;
  logic [63:0]       gsum;

  logic [IDX_W-1:0]  rd_addr;
  logic [TYPE_W-1:0] cur_idx;
  logic [63:0]       ocur_sel, fcur_sel;
  logic [63:0]       req;
  logic [63:0]       eff;
  logic [63:0]       add_a, add_b;
  logic [64:0]       sum;
  logic [63:0]       aligned;
  logic              is_last;
  logic              out_free;

  assign rd_addr  = (state == S_IDLE) ? cmd.page_slab[IDX_W-1:0] : idx;
  assign cur_idx  = (state == S_TY_SUB) ? k : type_rd;
  assign ocur_sel = ocur[cur_idx];
  assign fcur_sel = fcur[cur_idx];
  assign req      = off_vld_rd ? off_rd : '0;
  assign eff      = short_f ? req : size_rd;
  assign is_last  = (total == '0) || ((CNT_W'(idx) + 1'b1) == total);
  assign out_free = !out_valid || out_ready;
  assign cmd_pop  = (state == S_IDLE) && cmd_avail;

  // One shared 64-bit adder with carry out serves every checked add.
  always_comb begin
    add_a = '0;
    add_b = '0;
    unique case (state)
      S_PG_CHK: begin
        add_a = req;
        add_b = lg_mask(p_log);
      end
      S_PG_ADD: begin
        add_a = acc;
        add_b = p_size;
      end
      S_FN_ORG_AL: begin
        add_a = ocur_sel;
        add_b = lg_mask(alog_rd);
      end
      S_FN_ORG_ADD: begin
        add_a = acc;
        add_b = size_rd;
      end
      S_FN_FIX_AL: begin
        add_a = fcur_sel;
        add_b = lg_mask(alog_rd);
      end
      S_FN_FIX_ADD: begin
        add_a = acc;
        add_b = eff;
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
    sum     = {1'b0, add_a} + {1'b0, add_b};
    aligned = sum[63:0] & ~add_b;
  end

  always_ff @(posedge clk) begin
    size_rd    <= size_mem[rd_addr];
    new_rd     <= new_mem[rd_addr];
    off_rd     <= off_mem[rd_addr];
    alog_rd    <= alog_mem[rd_addr];
    type_rd    <= type_mem[rd_addr];
    off_vld_rd <= off_vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_avail && cmd.op == OP_SLAB && !failed && !pages_started &&
        total != CNT_W'(MAX_SLABS)) begin
      size_mem[total[IDX_W-1:0]] <= cmd.slab_size;
      alog_mem[total[IDX_W-1:0]] <= cmd.align_log;
      type_mem[total[IDX_W-1:0]] <= cmd.slab_type[TYPE_W-1:0];
    end
    if (state == S_PG_ADD && !sum[64]) begin
      off_mem[idx] <= sum[63:0];
    end
    if (state == S_FN_REP) begin
      new_mem[idx] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      total         <= '0;
      pages_started <= 1'b0;
      failed        <= 1'b0;
      repairs       <= '0;
      bytes_added   <= '0;
      off_vld       <= '0;
      rep           <= '0;
      ok            <= 1'b0;
      idx           <= '0;
      k             <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < BUFFER_TYPES; i++) begin
        ocur[i] <= '0;
        fcur[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready && state != S_EM_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_avail) begin
            unique case (cmd.op)
              OP_SLAB: begin
                if (!failed) begin
                  if (pages_started || total == CNT_W'(MAX_SLABS)) begin
                    failed <= 1'b1;
                  end else begin
                    failed <= !cmd.align_ok;
                    total  <= total + 1'b1;
                  end
                end
              end
              OP_PAGE: begin
                pages_started <= 1'b1;
                if (!failed) begin
                  if (cmd.page_slab >= 32'(total) || !cmd.align_ok || cmd.page_neg) begin
                    failed <= 1'b1;
                  end else begin
                    idx    <= cmd.page_slab[IDX_W-1:0];
                    p_log  <= cmd.align_log;
                    p_size <= 64'(cmd.page_size);
                    state  <= S_PG_CHK;
                  end
                end
              end
              OP_FINISH: begin
                ok   <= !failed;
                rep  <= '0;
                idx  <= '0;
                k    <= '0;
                gsum <= '0;
                if (failed) begin
                  state <= S_EM_RD;
                end else if (total != '0) begin
                  state <= S_FN_RD;
                end else begin
                  state <= S_TY_SUB;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_PG_CHK: begin
          if ((type_rd != '0 && p_log > alog_rd) || sum[64]) begin
            failed <= 1'b1;
            state  <= S_IDLE;
          end else begin
            acc   <= aligned;
            state <= S_PG_ADD;
          end
        end
        S_PG_ADD: begin
          if (sum[64]) begin
            failed <= 1'b1;
          end else begin
            off_vld[idx] <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_FN_RD: begin
          state <= S_FN_ORG_AL;
        end
        S_FN_ORG_AL: begin
          short_f <= size_rd < req;
          rep_amt <= req - size_rd;
          if (sum[64]) begin
            ok    <= 1'b0;
            idx   <= '0;
            state <= S_EM_RD;
          end else begin
            acc   <= aligned;
            state <= S_FN_ORG_ADD;
          end
        end
        S_FN_ORG_ADD: begin
          lim <= cfg.max_total_repair - rep_amt;
          if (sum[64] || (short_f && (!cfg.repair_enable || type_rd == '0 ||
              rep_amt > cfg.max_slab_repair || rep_amt > cfg.max_total_repair))) begin
            ok    <= 1'b0;
            idx   <= '0;
            state <= S_EM_RD;
          end else begin
            ocur[type_rd] <= sum[63:0];
            state         <= short_f ? S_FN_REP : S_FN_FIX_AL;
          end
        end
        S_FN_REP: begin
          if (bytes_added > lim || !(rep_amt <= cfg.max_uncond_repair ||
              (size_rd != '0 && rep_amt <= (size_rd >> 2)))) begin
            ok    <= 1'b0;
            idx   <= '0;
            state <= S_EM_RD;
          end else begin
            rep[idx]    <= 1'b1;
            repairs     <= repairs + 1'b1;
            bytes_added <= bytes_added + rep_amt;
            state       <= S_FN_FIX_AL;
          end
        end
        S_FN_FIX_AL: begin
          if (sum[64]) begin
            ok    <= 1'b0;
            idx   <= '0;
            state <= S_EM_RD;
          end else begin
            acc   <= aligned;
            state <= S_FN_FIX_ADD;
          end
        end
        S_FN_FIX_ADD: begin
          if (sum[64]) begin
            ok    <= 1'b0;
            idx   <= '0;
            state <= S_EM_RD;
          end else begin
            fcur[type_rd] <= sum[63:0];
            if ((CNT_W'(idx) + 1'b1) == total) begin
              idx   <= '0;
              state <= S_TY_SUB;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_FN_RD;
            end
          end
        end
        S_TY_SUB: begin
          g <= fcur_sel - ocur_sel;
          if (fcur_sel < ocur_sel) begin
            ok    <= 1'b0;
            state <= S_EM_RD;
          end else begin
            state <= S_TY_LIM;
          end
        end
        S_TY_LIM: begin
          lim <= cfg.max_total_repair - g;
          if (g > cfg.max_total_repair) begin
            ok    <= 1'b0;
            state <= S_EM_RD;
          end else begin
            state <= S_TY_ADD;
          end
        end
        S_TY_ADD: begin
          gsum <= gsum + g;
          if (gsum > lim) begin
            ok    <= 1'b0;
            state <= S_EM_RD;
          end else if (k == TYPE_W'(BUFFER_TYPES - 1)) begin
            state <= S_EM_RD;
          end else begin
            k     <= k + 1'b1;
            state <= S_TY_SUB;
          end
        end
        S_EM_RD: begin
          state <= S_EM_OUT;
        end
        S_EM_OUT: begin
          if (out_free) begin
            out_valid              <= 1'b1;
            out_data.slab_position <= (total == '0) ? '0 : 6'(idx);
            out_data.new_slab_size <= (total == '0) ? '0 :
                                      ((ok && rep[idx]) ? new_rd : size_rd);
            out_data.was_repaired  <= ok && rep[idx];
            out_data.valid_res     <= ok;
            out_data.repair_count  <= ok ? 7'(repairs) : '0;
            out_data.added_bytes   <= ok ? bytes_added : '0;
            out_data.last          <= is_last;
            if (is_last) begin
              total         <= '0;
              pages_started <= 1'b0;
              failed        <= 1'b0;
              repairs       <= '0;
              bytes_added   <= '0;
              off_vld       <= '0;
              for (int i = 0; i < BUFFER_TYPES; i++) begin
                ocur[i] <= '0;
                fcur[i] <= '0;
              end
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_EM_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/svr_checker.sv
module svr_checker
  import svr_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data,
  input logic      pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.valid_res |->
      out_data.repair_count == '0 && out_data.added_bytes == '0 && !out_data.was_repaired)
    else $error("invalid layout reports repairs");

  a_repair_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.was_repaired |-> out_data.repair_count != '0)
    else $error("repaired slab with zero repair count");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind slab_layout_validate_repair svr_checker u_svr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);
